>>> design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the convolution unit.
// No dependencies; the synthesis flow defines SYNTH to drop the bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/flc_pkg.sv
// Package of the convolution unit: sizes, payload types, FSM states and
// the command and status groups between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package flc_pkg;

	// Default signal capacity, fixed sample width and result width.
	localparam int MAX_LEN_DEF  = 32;
	localparam int SAMPLE_WIDTH = 16;
	localparam int OUT_WIDTH    = 37;

	// One input request.
	typedef struct packed {
		logic                           req_type;
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           last;
	} in_req_t;

	// One result request.
	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] conv_value;
		logic                        last_out;
		logic                        truncated;
	} out_res_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROW,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic row_init;
		logic issue;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic complete;
		logic row_end;
		logic pipe_empty;
		logic run_last;
		logic out_free;
	} status_t;

endpackage

>>> design/flc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module flc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/flc_ctrl.sv
// Controller of the convolution unit: sequences loading, row setup,
// multiply-accumulate issue and result hand-off. Depends on flc_pkg.
`timescale 1ns / 1ps

module flc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  flc_pkg::status_t status,
	output flc_pkg::cmd_t    cmd
);

	flc_pkg::state_t state_q;
	flc_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flc_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			flc_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.complete) begin
						state_d = flc_pkg::ST_ROW;
					end
				end
			end
			flc_pkg::ST_ROW: begin
				cmd.row_init = 1'b1;
				state_d      = flc_pkg::ST_ISSUE;
			end
			flc_pkg::ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (status.row_end) begin
					state_d = flc_pkg::ST_DRAIN;
				end
			end
			flc_pkg::ST_DRAIN: begin
				// Wait for the last product to land, then hand the sum over.
				if (status.pipe_empty && status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = status.run_last ? flc_pkg::ST_LOAD : flc_pkg::ST_ROW;
				end
			end
			default: begin
				state_d = flc_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

>>> design/flc_datapath.sv
// Datapath of the convolution unit: sample stores, counts and flags, index
// counters, the multiply-accumulate pipeline and the output register.
// Depends on flc_pkg and flc_ram.
`timescale 1ns / 1ps

module flc_datapath #(
	parameter int MAX_LEN = flc_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  flc_pkg::in_req_t  in_data,
	input  flc_pkg::cmd_t     cmd,
	output flc_pkg::status_t  status,
	output logic              out_valid,
	input  logic              out_ready,
	output flc_pkg::out_res_t out_data
);

	localparam int SW = flc_pkg::SAMPLE_WIDTH;
	localparam int OW = flc_pkg::OUT_WIDTH;
	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int IW = $clog2(2 * MAX_LEN);

	// Run state.
	logic [CW-1:0] first_count_q;
	logic [CW-1:0] second_count_q;
	logic          first_done_q;
	logic          second_done_q;
	logic          overflow_q;

	// Output index and per-row indexes into the two stores.
	logic [IW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] k_q;

	// Multiply-accumulate pipeline.
	logic                   rd_s1;
	logic                   v_s2;
	logic signed [2*SW-1:0] prod_s2;
	logic        [OW-1:0]   acc_q;

	// Output register.
	logic               out_valid_q;
	flc_pkg::out_res_t  out_q;

	// Store ports.
	logic          first_we;
	logic          second_we;
	logic [SW-1:0] first_rd;
	logic [SW-1:0] second_rd;

	// Row bounds.
	logic [IW-1:0] n1m1;
	logic [IW-1:0] n2m1;
	logic [IW-1:0] lo;
	logic [IW-1:0] hi;
	logic [IW-1:0] k0;
	logic [IW-1:0] total_m1;

	logic first_full;
	logic second_full;
	logic drop;

	// Load decisions for the incoming request.
	always_comb begin
		first_full  = (first_count_q == CW'(MAX_LEN));
		second_full = (second_count_q == CW'(MAX_LEN));
		first_we    = cmd.load && !in_data.req_type && !first_done_q && !first_full;
		second_we   = cmd.load && in_data.req_type && !second_done_q && !second_full;
		drop        = cmd.load && (in_data.req_type ? (!second_done_q && second_full)
		                                            : (!first_done_q && first_full));
	end

	// Row bounds of the current output.
	always_comb begin
		n1m1     = IW'(first_count_q) - IW'(1);
		n2m1     = IW'(second_count_q) - IW'(1);
		lo       = (i_q >= n2m1) ? (i_q - n2m1) : '0;
		hi       = (i_q < n1m1) ? i_q : n1m1;
		k0       = i_q - lo;
		total_m1 = n1m1 + n2m1;
	end

	// Status toward the controller.
	always_comb begin
		status.complete   = in_data.req_type ? (first_done_q && (second_done_q || in_data.last))
		                                     : (second_done_q && (first_done_q || in_data.last));
		status.row_end    = (IW'(j_q) == hi);
		status.pipe_empty = !rd_s1 && !v_s2;
		status.run_last   = (i_q == total_m1);
		status.out_free   = !out_valid_q || out_ready;
	end

	// Sample stores.
	flc_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_LEN)
	) u_first_store (
		.clk   (clk),
		.we    (first_we),
		.waddr (first_count_q[AW-1:0]),
		.wdata (in_data.sample),
		.raddr (j_q),
		.rdata (first_rd)
	);

	flc_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_LEN)
	) u_second_store (
		.clk   (clk),
		.we    (second_we),
		.waddr (second_count_q[AW-1:0]),
		.wdata (in_data.sample),
		.raddr (k_q),
		.rdata (second_rd)
	);

	// Counts, flags, output index, pipeline valids and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_count_q  <= '0;
			second_count_q <= '0;
			first_done_q   <= 1'b0;
			second_done_q  <= 1'b0;
			overflow_q     <= 1'b0;
			i_q            <= '0;
			rd_s1          <= 1'b0;
			v_s2           <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			rd_s1 <= cmd.issue;
			v_s2  <= rd_s1;
			if (first_we) begin
				first_count_q <= first_count_q + CW'(1);
			end
			if (second_we) begin
				second_count_q <= second_count_q + CW'(1);
			end
			if (drop) begin
				overflow_q <= 1'b1;
			end
			if (cmd.load && in_data.last) begin
				if (in_data.req_type) begin
					second_done_q <= 1'b1;
				end else begin
					first_done_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (status.run_last) begin
					// Run finished: the stores count as empty again.
					first_count_q  <= '0;
					second_count_q <= '0;
					first_done_q   <= 1'b0;
					second_done_q  <= 1'b0;
					overflow_q     <= 1'b0;
					i_q            <= '0;
				end else begin
					i_q <= i_q + IW'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Indexes, product, accumulator and result payload.
	always_ff @(posedge clk) begin
		if (cmd.row_init) begin
			j_q <= lo[AW-1:0];
			k_q <= k0[AW-1:0];
		end else if (cmd.issue) begin
			j_q <= j_q + AW'(1);
			k_q <= k_q - AW'(1);
		end
		prod_s2 <= $signed(first_rd) * $signed(second_rd);
		if (cmd.row_init) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(OW - 2*SW){prod_s2[2*SW-1]}}, prod_s2};
		end
		if (cmd.emit) begin
			out_q.conv_value <= acc_q;
			out_q.last_out   <= status.run_last;
			out_q.truncated  <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> design/full_linear_convolution_unit.sv
// Loading: one input request per cycle while no run is being computed; inputs stall meanwhile.
// Each result of a run takes a row setup, issues its products into the pipeline, drains the
// read, multiply and add stages, then waits for a free output register to hand the sum over.
// Reset (arst_n low) empties both signals and drops any pending result.
// Depends on flc_pkg, flc_ctrl, flc_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module full_linear_convolution_unit #(
	parameter int MAX_LEN = flc_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  flc_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output flc_pkg::out_res_t out_data
);

	flc_pkg::cmd_t    cmd;
	flc_pkg::status_t status;

	// Controller.
	flc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	flc_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// A result is only moved into the output register when it has room.
	`ASSERT_IMPLIES(a_emit_has_room, clk, arst_n, cmd.emit, status.out_free)
	// The final result of a run reopens the input side.
	`ASSERT_NEXT(a_last_reopens, clk, arst_n, cmd.emit && status.run_last, in_ready)
	// The request that completes a run closes the input side.
	`ASSERT_NEXT(a_start_closes, clk, arst_n, in_valid && in_ready && status.complete, !in_ready)
	// Every issued read enters the multiply-accumulate pipeline.
	`ASSERT_NEXT(a_issue_fills, clk, arst_n, cmd.issue, !status.pipe_empty)

endmodule
